### design/srbm_pkg.sv
// Package for the row sort block: chain entry and control types, register indexes.
// Depends on nothing; every other file of the block imports it.
package srbm_pkg;

	localparam int KEY_W = 32;
	localparam int IDX_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic valid;
		logic signed [KEY_W-1:0] key;
		logic [IDX_W-1:0] idx;
	} entry_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_INSERT,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		entry_t ent;
	} chain_ctrl_t;

endpackage

### design/srbm_cell.sv
// One cell of the sorted row chain: holds a row minimum and its source row.
// Depends on srbm_pkg.
module srbm_cell (
	input logic clk,
	input logic arst_n,
	input srbm_pkg::chain_ctrl_t ctrl,
	input srbm_pkg::entry_t prev_e,
	input srbm_pkg::entry_t next_e,
	output srbm_pkg::entry_t cur_e
);
	import srbm_pkg::*;

	entry_t cur_q;
	logic gt_prev;
	logic gt_self;

	// An empty cell counts as minus infinity; a tie does not win, which keeps
	// rows with equal minima in arrival order.
	always_comb begin
		gt_prev = !prev_e.valid || ($signed(ctrl.ent.key) > $signed(prev_e.key));
		gt_self = !cur_q.valid || ($signed(ctrl.ent.key) > $signed(cur_q.key));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.valid <= 1'b0;
		end else begin
			unique case (ctrl.op)
				CELL_HOLD: begin
				end
				CELL_CLEAR: begin
					cur_q.valid <= 1'b0;
				end
				CELL_INSERT: begin
					if (gt_prev) begin
						cur_q <= prev_e;
					end else if (gt_self) begin
						cur_q <= ctrl.ent;
					end
				end
				CELL_SHIFT: begin
					cur_q <= next_e;
				end
				default: begin
				end
			endcase
		end
	end

	assign cur_e = cur_q;

endmodule

### design/srbm_chain.sv
// Row of sort cells kept in descending order of row minimum, head first.
// Depends on srbm_pkg and srbm_cell.
module srbm_chain #(
	parameter int DEPTH = 8
) (
	input logic clk,
	input logic arst_n,
	input srbm_pkg::chain_ctrl_t ctrl,
	output srbm_pkg::entry_t head
);
	import srbm_pkg::*;

	entry_t cells [DEPTH];
	entry_t top_guard;
	entry_t tail_guard;

	// The guard above the head never loses a compare; the one below the tail is empty.
	always_comb begin
		top_guard.valid = 1'b1;
		top_guard.key = KEY_MAX;
		top_guard.idx = '0;
		tail_guard.valid = 1'b0;
		tail_guard.key = '0;
		tail_guard.idx = '0;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		if (i == 0) begin : g_first
			assign prev_e = top_guard;
		end else begin : g_mid
			assign prev_e = cells[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_e = tail_guard;
		end else begin : g_inner
			assign next_e = cells[i+1];
		end
		srbm_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.prev_e(prev_e),
			.next_e(next_e),
			.cur_e(cells[i])
		);
	end

	assign head = cells[0];

endmodule

### design/sort_rows_by_min_desc.sv
// Top level of the row sort block: load counters, element memory, chain and output sequencer.
// Depends on srbm_pkg and srbm_chain.
//
// Usage. Elements of a matrix arrive in row-major order on element_value; a word is
// taken at a rising edge where start is high and busy is low, one per cycle if the
// sender wishes. Each finished row's minimum is inserted at once into a chain of
// cells ordered by descending minimum (stable for equal minima), so the order is
// ready when the final element arrives. From the next cycle busy stays high while
// the sequencer walks the chain head and reads the element memory, one word per
// cycle; each result appears in the cycle after its read, for one cycle, marked by
// out_valid, with last_element on the final one. Loading and emission do not
// overlap, since no element is taken while busy. The receiver cannot stall. The
// configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets row_count
// (index 0) and col_count (index 1); a write restarts the load and is taken only
// while not busy. Reset clears counters, chain and output strobe, and sets both
// dimensions to 8; the memory is not cleared.
module sort_rows_by_min_desc #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [31:0] element_value,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [srbm_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [srbm_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic out_valid,
	output logic signed [31:0] out_value,
	output logic [2:0] out_row,
	output logic [2:0] out_col,
	output logic last_element
);
	import srbm_pkg::*;

	localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	logic [CFG_DATA_W-1:0] row_count_q;
	logic [CFG_DATA_W-1:0] col_count_q;
	logic [RIW-1:0] rows_m1;
	logic [CIW-1:0] cols_m1;

	logic [RIW-1:0] load_row_q;
	logic [CIW-1:0] load_col_q;
	logic signed [31:0] min_q;
	logic signed [31:0] new_min;

	logic emit_q;
	logic [RIW-1:0] emit_row_q;
	logic [CIW-1:0] emit_col_q;

	logic [31:0] mem_q [MEM_DEPTH];
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	logic signed [31:0] value_s1;
	logic valid_s1;
	logic [RIW-1:0] row_s1;
	logic [CIW-1:0] col_s1;
	logic last_s1;

	logic accept;
	logic cfg_write;
	logic load_row_end;
	logic load_mat_end;
	logic emit_row_end;
	logic emit_mat_end;

	chain_ctrl_t chain_ctrl;
	entry_t head;

	// A dimension of zero is used as one; one beyond the maximum saturates.
	always_comb begin
		if (row_count_q == '0) begin
			rows_m1 = '0;
		end else if (32'(row_count_q) > MAX_ROWS) begin
			rows_m1 = RIW'(MAX_ROWS - 1);
		end else begin
			rows_m1 = RIW'(row_count_q - 4'd1);
		end
		if (col_count_q == '0) begin
			cols_m1 = '0;
		end else if (32'(col_count_q) > MAX_COLS) begin
			cols_m1 = CIW'(MAX_COLS - 1);
		end else begin
			cols_m1 = CIW'(col_count_q - 4'd1);
		end
	end

	assign busy = emit_q;
	assign cfg_ready = !emit_q;
	assign accept = start && !emit_q;
	assign cfg_write = cfg_valid && cfg_ready
		&& (cfg_index == REG_ROW_COUNT || cfg_index == REG_COL_COUNT);

	assign load_row_end = (load_col_q == cols_m1);
	assign load_mat_end = load_row_end && (load_row_q == rows_m1);
	assign emit_row_end = (emit_col_q == cols_m1);
	assign emit_mat_end = emit_row_end && (emit_row_q == rows_m1);

	assign new_min = (load_col_q == '0 || element_value < min_q) ? element_value : min_q;

	assign wr_addr = AW'(32'(load_row_q) * MAX_COLS + 32'(load_col_q));
	assign rd_addr = AW'(32'(head.idx) * MAX_COLS + 32'(emit_col_q));

	// Chain control: a configuration write clears the chain and a finished row is inserted;
	// during output the head row leaves at each row end; the chain empties after the last row.
	always_comb begin
		chain_ctrl.op = CELL_HOLD;
		chain_ctrl.ent.valid = 1'b1;
		chain_ctrl.ent.key = new_min;
		chain_ctrl.ent.idx = IDX_W'(load_row_q);
		priority if (cfg_write) begin
			chain_ctrl.op = CELL_CLEAR;
		end else if (accept && load_row_end) begin
			chain_ctrl.op = CELL_INSERT;
		end else if (emit_q && emit_mat_end) begin
			chain_ctrl.op = CELL_CLEAR;
		end else if (emit_q && emit_row_end) begin
			chain_ctrl.op = CELL_SHIFT;
		end else begin
			chain_ctrl.op = CELL_HOLD;
		end
	end

	srbm_chain #(
		.DEPTH(MAX_ROWS)
	) u_chain (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(chain_ctrl),
		.head(head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= 4'd8;
			col_count_q <= 4'd8;
			load_row_q <= '0;
			load_col_q <= '0;
		end else if (cfg_write) begin
			if (cfg_index == REG_ROW_COUNT) begin
				row_count_q <= cfg_data;
			end else begin
				col_count_q <= cfg_data;
			end
			load_row_q <= '0;
			load_col_q <= '0;
		end else if (accept) begin
			if (load_row_end) begin
				load_col_q <= '0;
				load_row_q <= load_mat_end ? '0 : load_row_q + 1'b1;
			end else begin
				load_col_q <= load_col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			min_q <= new_min;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b0;
			emit_row_q <= '0;
			emit_col_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= emit_q;
			if (accept && load_mat_end) begin
				emit_q <= 1'b1;
				emit_row_q <= '0;
				emit_col_q <= '0;
			end else if (emit_q) begin
				if (emit_row_end) begin
					emit_col_q <= '0;
					emit_row_q <= emit_row_q + 1'b1;
					if (emit_mat_end) begin
						emit_q <= 1'b0;
					end
				end else begin
					emit_col_q <= emit_col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem_q[wr_addr] <= element_value;
		end
		if (emit_q) begin
			value_s1 <= mem_q[rd_addr];
		end
		row_s1 <= emit_row_q;
		col_s1 <= emit_col_q;
		last_s1 <= emit_mat_end;
	end

	assign out_valid = valid_s1;
	assign out_value = value_s1;
	assign out_row = 3'(row_s1);
	assign out_col = 3'(col_s1);
	assign last_element = valid_s1 && last_s1;

`ifndef NO_ASSERTIONS
	a_out_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(emit_q))
		else $error("result word without an emission cycle before it");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_element) |=> !out_valid)
		else $error("result word directly after the final word of a matrix");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit_q |-> head.valid)
		else $error("emission with an empty chain head");

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy raised without an accepted element");
`endif

endmodule
